[src/vmpg_pkg.sv]
`default_nettype none
package vmpg_pkg;

  localparam int GLYPH_DEPTH = 1024;
  localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
  localparam int PENS_PER_COL = 14;
  localparam int COL_W       = 4 * PENS_PER_COL;

  typedef logic [3:0]          pen_t;
  typedef logic [GLYPH_AW-1:0] glyph_addr_t;
  typedef logic [COL_W-1:0]    col_pens_t;

  localparam pen_t PEN_BLACK = 4'd0;
  localparam pen_t PEN_GREEN = 4'd12;
  localparam pen_t PEN_WHITE = 4'd15;

  typedef enum logic [2:0] {
    MODE_TEXT40       = 3'd0,
    MODE_TEXT40_COLOR = 3'd1,
    MODE_TEXT80       = 3'd2,
    MODE_TEXT80_ALT   = 3'd3,
    MODE_HIRES        = 3'd4,
    MODE_HIRES_COLOR  = 3'd5,
    MODE_SUPER        = 3'd6,
    MODE_CHUNKY       = 3'd7
  } mode_t;

  typedef enum logic {
    OP_RENDER = 1'b0,
    OP_WRITE  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [2:0]  glyph_row;
    logic [7:0]  main_even;
    logic [7:0]  aux_even;
    logic [7:0]  main_odd;
    logic [7:0]  aux_odd;
    logic [9:0]  glyph_address;
    logic [7:0]  glyph_data;
  } in_beat_t;

  typedef struct packed {
    logic [COL_W-1:0] pixels_even;
    logic [COL_W-1:0] pixels_odd;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] main_b;
    logic [7:0] aux_b;
  } col_bytes_t;

  typedef struct packed {
    logic        en;
    glyph_addr_t addr;
    logic [7:0]  data;
  } glyph_wr_t;

  function automatic pen_t nib_rev(input logic [3:0] n);
    return {n[0], n[1], n[2], n[3]};
  endfunction

endpackage
`default_nettype wire

[src/vmpg_ram.sv]
`default_nettype none
module vmpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[src/vmpg_lane.sv]
`default_nettype none
module vmpg_lane (
  input  wire logic                   clk,
  input  wire vmpg_pkg::glyph_wr_t    wr,
  input  wire logic                   rd_en,
  input  wire vmpg_pkg::col_bytes_t   rd_col,
  input  wire logic [2:0]             rd_row,
  input  wire vmpg_pkg::mode_t        mode,
  input  wire vmpg_pkg::col_bytes_t   col,
  output vmpg_pkg::col_pens_t         pens
);

  logic [7:0] glyph_main;
  logic [7:0] glyph_aux;
  vmpg_pkg::glyph_addr_t addr_main;
  vmpg_pkg::glyph_addr_t addr_aux;

  assign addr_main = vmpg_pkg::glyph_addr_t'({rd_col.main_b[6:0], rd_row});
  assign addr_aux  = vmpg_pkg::glyph_addr_t'({rd_col.aux_b[6:0], rd_row});

  // one glyph copy per character slot so text80 gets both reads at once
  vmpg_ram #(.WIDTH(8), .DEPTH(vmpg_pkg::GLYPH_DEPTH)) u_ram_main (
    .clk    (clk),
    .wr_en  (wr.en),
    .wr_addr(wr.addr),
    .wr_data(wr.data),
    .rd_en  (rd_en),
    .rd_addr(addr_main),
    .rd_data(glyph_main)
  );

  vmpg_ram #(.WIDTH(8), .DEPTH(vmpg_pkg::GLYPH_DEPTH)) u_ram_aux (
    .clk    (clk),
    .wr_en  (wr.en),
    .wr_addr(wr.addr),
    .wr_data(wr.data),
    .rd_en  (rd_en),
    .rd_addr(addr_aux),
    .rd_data(glyph_aux)
  );

  always_comb begin
    vmpg_pkg::pen_t fg_c;
    vmpg_pkg::pen_t bg_c;
    vmpg_pkg::pen_t fg;
    vmpg_pkg::pen_t bg;
    vmpg_pkg::pen_t fg2;
    vmpg_pkg::pen_t bg2;
    pens = '0;
    fg_c = vmpg_pkg::PEN_GREEN;
    bg_c = vmpg_pkg::PEN_BLACK;
    fg   = vmpg_pkg::PEN_GREEN;
    bg   = vmpg_pkg::PEN_BLACK;
    fg2  = vmpg_pkg::PEN_GREEN;
    bg2  = vmpg_pkg::PEN_BLACK;
    unique case (mode)
      vmpg_pkg::MODE_TEXT40, vmpg_pkg::MODE_TEXT40_COLOR: begin
        if (mode == vmpg_pkg::MODE_TEXT40_COLOR) begin
          fg_c = col.aux_b[7:4];
          bg_c = col.aux_b[3:0];
        end
        // inverse video when bit 7 of the character is clear
        fg = col.main_b[7] ? fg_c : bg_c;
        bg = col.main_b[7] ? bg_c : fg_c;
        for (int i = 0; i < 7; i++) begin
          pens[8*i +: 4]     = glyph_main[i] ? fg : bg;
          pens[8*i + 4 +: 4] = glyph_main[i] ? fg : bg;
        end
      end
      vmpg_pkg::MODE_TEXT80, vmpg_pkg::MODE_TEXT80_ALT: begin
        fg  = col.main_b[7] ? vmpg_pkg::PEN_GREEN : vmpg_pkg::PEN_BLACK;
        bg  = col.main_b[7] ? vmpg_pkg::PEN_BLACK : vmpg_pkg::PEN_GREEN;
        fg2 = col.aux_b[7]  ? vmpg_pkg::PEN_GREEN : vmpg_pkg::PEN_BLACK;
        bg2 = col.aux_b[7]  ? vmpg_pkg::PEN_BLACK : vmpg_pkg::PEN_GREEN;
        for (int i = 0; i < 7; i++) begin
          pens[4*i +: 4]       = glyph_main[i] ? fg : bg;
          pens[4*(i + 7) +: 4] = glyph_aux[i] ? fg2 : bg2;
        end
      end
      vmpg_pkg::MODE_HIRES, vmpg_pkg::MODE_HIRES_COLOR: begin
        if (mode == vmpg_pkg::MODE_HIRES_COLOR) begin
          fg = vmpg_pkg::nib_rev(col.aux_b[7:4]);
          bg = vmpg_pkg::nib_rev(col.aux_b[3:0]);
        end else begin
          fg = vmpg_pkg::PEN_WHITE;
          bg = vmpg_pkg::PEN_BLACK;
        end
        for (int i = 0; i < 7; i++) begin
          pens[8*i +: 4]     = col.main_b[i] ? fg : bg;
          pens[8*i + 4 +: 4] = col.main_b[i] ? fg : bg;
        end
      end
      vmpg_pkg::MODE_SUPER, vmpg_pkg::MODE_CHUNKY: begin
        // chunky is replaced in the merge stage
        for (int i = 0; i < 7; i++) begin
          pens[8*i +: 4]     = col.main_b[i] ? vmpg_pkg::PEN_WHITE : vmpg_pkg::PEN_BLACK;
          pens[8*i + 4 +: 4] = col.aux_b[i]  ? vmpg_pkg::PEN_WHITE : vmpg_pkg::PEN_BLACK;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

[src/vmpg_merge.sv]
`default_nettype none
module vmpg_merge (
  input  wire vmpg_pkg::mode_t       mode,
  input  wire vmpg_pkg::col_bytes_t  col_even,
  input  wire vmpg_pkg::col_bytes_t  col_odd,
  input  wire vmpg_pkg::col_pens_t   pens_even,
  input  wire vmpg_pkg::col_pens_t   pens_odd,
  output vmpg_pkg::out_beat_t        beat
);

  logic [31:0]              word;
  vmpg_pkg::pen_t           chunk [7];
  logic [2*vmpg_pkg::COL_W-1:0] chunky_pens;

  assign word = {col_odd.aux_b, col_odd.main_b, col_even.aux_b, col_even.main_b};

  // 7-bit fields straddle the pen nibbles; the top bit of some pens repeats
  // the lowest bit of the same field
  assign chunk[0] = word[3:0];
  assign chunk[1] = {word[4], word[6:4]};
  assign chunk[2] = word[12:9];
  assign chunk[3] = {word[17:16], word[14:13]};
  assign chunk[4] = word[21:18];
  assign chunk[5] = {word[26:24], word[22]};
  assign chunk[6] = word[30:27];

  always_comb begin
    for (int i = 0; i < 2 * vmpg_pkg::PENS_PER_COL; i++) begin
      chunky_pens[4*i +: 4] = chunk[i / 4];
    end
  end

  always_comb begin
    if (mode == vmpg_pkg::MODE_CHUNKY) begin
      beat.pixels_even = chunky_pens[vmpg_pkg::COL_W-1:0];
      beat.pixels_odd  = chunky_pens[2*vmpg_pkg::COL_W-1:vmpg_pkg::COL_W];
    end else begin
      beat.pixels_even = pens_even;
      beat.pixels_odd  = pens_odd;
    end
  end

endmodule
`default_nettype wire

[src/video_mode_pixel_generator.sv]
`default_nettype none
// After acceptance a render beat passes the glyph memory read, then pen build
// and merge into the output register. One beat per cycle is taken while the
// output is not stalled and no glyph clear runs; glyph writes return nothing.
// Each column lane owns two copies of the glyph store so text80 gets all four
// glyph reads in the same cycle. After reset all GLYPH_DEPTH (1024) entries of
// the glyph store are cleared one entry a cycle, with in_stall high; mode
// writes are taken during that pass.
module video_mode_pixel_generator (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire vmpg_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output vmpg_pkg::out_beat_t       out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [2:0]           cfg_wr_data
);

  vmpg_pkg::mode_t       mode_r;
  logic                  clr_busy_r;
  vmpg_pkg::glyph_addr_t clr_cnt_r;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  vmpg_pkg::col_bytes_t  s1_even_r;
  vmpg_pkg::col_bytes_t  s1_odd_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  vmpg_pkg::out_beat_t   out_data_r;

  logic                  accept;
  logic                  render_acc;
  logic                  out_free;
  vmpg_pkg::glyph_wr_t   glyph_wr;
  vmpg_pkg::col_bytes_t  acc_even;
  vmpg_pkg::col_bytes_t  acc_odd;
  vmpg_pkg::col_pens_t   pens_even;
  vmpg_pkg::col_pens_t   pens_odd;
  vmpg_pkg::out_beat_t   merged;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = clr_busy_r || (s1_valid_r && !out_free);
  assign accept     = in_valid && !in_stall;
  assign render_acc = accept && (in_data.opcode == vmpg_pkg::OP_RENDER);

  assign acc_even = '{main_b: in_data.main_even, aux_b: in_data.aux_even};
  assign acc_odd  = '{main_b: in_data.main_odd,  aux_b: in_data.aux_odd};

  always_comb begin
    if (clr_busy_r) begin
      glyph_wr.en   = 1'b1;
      glyph_wr.addr = clr_cnt_r;
      glyph_wr.data = '0;
    end else begin
      glyph_wr.en   = accept && (in_data.opcode == vmpg_pkg::OP_WRITE);
      glyph_wr.addr = vmpg_pkg::glyph_addr_t'(in_data.glyph_address);
      glyph_wr.data = in_data.glyph_data;
    end
  end

  assign s1_valid_nxt  = (s1_valid_r && !out_free) || render_acc;
  assign out_valid_nxt = out_free ? s1_valid_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= vmpg_pkg::MODE_TEXT40;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= vmpg_pkg::mode_t'(cfg_wr_data);
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == vmpg_pkg::glyph_addr_t'(vmpg_pkg::GLYPH_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (render_acc) begin
      s1_even_r <= acc_even;
      s1_odd_r  <= acc_odd;
    end
    if (out_free && s1_valid_r) begin
      out_data_r <= merged;
    end
  end

  vmpg_lane u_lane_even (
    .clk   (clk),
    .wr    (glyph_wr),
    .rd_en (render_acc),
    .rd_col(acc_even),
    .rd_row(in_data.glyph_row),
    .mode  (mode_r),
    .col   (s1_even_r),
    .pens  (pens_even)
  );

  vmpg_lane u_lane_odd (
    .clk   (clk),
    .wr    (glyph_wr),
    .rd_en (render_acc),
    .rd_col(acc_odd),
    .rd_row(in_data.glyph_row),
    .mode  (mode_r),
    .col   (s1_odd_r),
    .pens  (pens_odd)
  );

  vmpg_merge u_merge (
    .mode     (mode_r),
    .col_even (s1_even_r),
    .col_odd  (s1_odd_r),
    .pens_even(pens_even),
    .pens_odd (pens_odd),
    .beat     (merged)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !accept)
    else $error("beat accepted during glyph clear");

  a_render_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    render_acc |=> s1_valid_r)
    else $error("render beat lost before stage 1");

  a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> (s1_valid_r && out_valid_r))
    else $error("stage 1 or output dropped under stall");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.opcode == vmpg_pkg::OP_WRITE && !s1_valid_r) |=> !s1_valid_r)
    else $error("glyph write produced a render beat");

  a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_free) |=> out_valid_r)
    else $error("stage 1 beat did not reach output");

endmodule
`default_nettype wire

[verif/tb.sv]
module tb;
  import vmpg_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = '0;

  video_mode_pixel_generator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow state of the block
  logic [7:0] glyph_mem [0:GLYPH_DEPTH-1];
  mode_t cur_mode = MODE_TEXT40;

  in_beat_t beats_pending[$];
  out_beat_t pens_due[$];
  logic in_took = 1'b0;
  int errs = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    for (int i = 0; i < GLYPH_DEPTH; i++) glyph_mem[i] = 8'h00;
  end

  function automatic pen_t flip_nibble(logic [3:0] n);
    pen_t r;
    for (int i = 0; i < 4; i++) r[i] = n[3 - i];
    return r;
  endfunction

  // seven source bits, each stretched over rep pens from pen slot pos
  function automatic col_pens_t paint(col_pens_t acc, int pos, logic [7:0] bits,
                                      pen_t fg, pen_t bg, int rep);
    for (int i = 0; i < 7; i++)
      for (int r = 0; r < rep; r++)
        acc[4*(pos + i*rep + r) +: 4] = bits[i] ? fg : bg;
    return acc;
  endfunction

  function automatic col_pens_t build_column(logic [7:0] mb, logic [7:0] ab, logic [2:0] row);
    col_pens_t acc;
    pen_t fg, bg, t;
    acc = '0;
    case (cur_mode)
      MODE_TEXT40, MODE_TEXT40_COLOR: begin
        if (cur_mode == MODE_TEXT40_COLOR) begin
          fg = ab[7:4];
          bg = ab[3:0];
        end else begin
          fg = PEN_GREEN;
          bg = PEN_BLACK;
        end
        // bit 7 clear means inverse
        if (!mb[7]) begin
          t = fg;
          fg = bg;
          bg = t;
        end
        acc = paint(acc, 0, glyph_mem[{mb[6:0], row}], fg, bg, 2);
      end
      MODE_TEXT80, MODE_TEXT80_ALT: begin
        acc = paint(acc, 0, glyph_mem[{mb[6:0], row}], mb[7] ? PEN_GREEN : PEN_BLACK,
                    mb[7] ? PEN_BLACK : PEN_GREEN, 1);
        acc = paint(acc, 7, glyph_mem[{ab[6:0], row}], ab[7] ? PEN_GREEN : PEN_BLACK,
                    ab[7] ? PEN_BLACK : PEN_GREEN, 1);
      end
      MODE_HIRES: acc = paint(acc, 0, mb, PEN_WHITE, PEN_BLACK, 2);
      MODE_HIRES_COLOR:
        acc = paint(acc, 0, mb, flip_nibble(ab[7:4]), flip_nibble(ab[3:0]), 2);
      default: begin
        for (int i = 0; i < 7; i++) begin
          acc[8*i +: 4] = mb[i] ? PEN_WHITE : PEN_BLACK;
          acc[8*i+4 +: 4] = ab[i] ? PEN_WHITE : PEN_BLACK;
        end
      end
    endcase
    return acc;
  endfunction

  function automatic out_beat_t render_pair(in_beat_t b);
    out_beat_t r;
    logic [31:0] word;
    logic [111:0] all;
    pen_t chunk [7];
    if (cur_mode == MODE_CHUNKY) begin
      // 7-bit fields; chunk 1 repeats its lowest bit as its top bit
      word = {b.aux_odd, b.main_odd, b.aux_even, b.main_even};
      chunk[0] = word[3:0];
      chunk[1] = {word[4], word[6:4]};
      chunk[2] = word[12:9];
      chunk[3] = {word[17:16], word[14:13]};
      chunk[4] = word[21:18];
      chunk[5] = {word[26:24], word[22]};
      chunk[6] = word[30:27];
      for (int i = 0; i < 28; i++) all[4*i +: 4] = chunk[i/4];
      r.pixels_even = all[55:0];
      r.pixels_odd = all[111:56];
    end else begin
      r.pixels_even = build_column(b.main_even, b.aux_even, b.glyph_row);
      r.pixels_odd = build_column(b.main_odd, b.aux_odd, b.glyph_row);
    end
    return r;
  endfunction

  function automatic in_beat_t render_beat(logic [2:0] row, logic [7:0] me, logic [7:0] ae,
                                           logic [7:0] mo, logic [7:0] ao);
    in_beat_t b;
    b = '0;
    b.opcode = OP_RENDER;
    b.glyph_row = row;
    b.main_even = me;
    b.aux_even = ae;
    b.main_odd = mo;
    b.aux_odd = ao;
    return b;
  endfunction

  function automatic in_beat_t write_beat(logic [9:0] addr, logic [7:0] data);
    in_beat_t b;
    b = '0;
    b.opcode = OP_WRITE;
    b.glyph_address = addr;
    b.glyph_data = data;
    return b;
  endfunction

  // glyph codes 0x40..0x4f form a hot set so text renders see written rows
  function automatic logic [6:0] hot_char();
    return {3'b100, 4'($urandom_range(15))};
  endfunction

  function automatic in_beat_t random_beat(int write_pct);
    in_beat_t b;
    b.opcode = ($urandom_range(99) < write_pct) ? OP_WRITE : OP_RENDER;
    b.glyph_row = 3'($urandom_range(7));
    b.main_even = 8'($urandom);
    b.aux_even = 8'($urandom);
    b.main_odd = 8'($urandom);
    b.aux_odd = 8'($urandom);
    b.glyph_address = 10'($urandom);
    b.glyph_data = 8'($urandom);
    if ($urandom_range(3) != 0) b.glyph_address = {hot_char(), 3'($urandom_range(7))};
    if ($urandom_range(3) != 0) b.main_even[6:0] = hot_char();
    if ($urandom_range(3) != 0) b.aux_even[6:0] = hot_char();
    if ($urandom_range(3) != 0) b.main_odd[6:0] = hot_char();
    if ($urandom_range(3) != 0) b.aux_odd[6:0] = hot_char();
    return b;
  endfunction

  task automatic wait_idle();
    while (beats_pending.size() != 0 || in_valid || pens_due.size() != 0) @(negedge clk);
    // a trailing glyph write may still be in the pipe
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(mode_t m);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // sender
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (rst_n && beats_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= beats_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // input tracking, prediction and result check
  always @(posedge clk) begin
    out_beat_t want;
    in_took = rst_n && in_valid && !in_stall;
    if (rst_n && cfg_wr_en) cur_mode = mode_t'(cfg_wr_data);
    if (in_took) begin
      if (in_data.opcode == OP_WRITE) glyph_mem[in_data.glyph_address] = in_data.glyph_data;
      else pens_due.push_back(render_pair(in_data));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pens_due.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data);
        errs++;
      end else begin
        want = pens_due.pop_front();
        if (out_data.pixels_even !== want.pixels_even) begin
          $display("%0t: pixels_even expected %h actual %h", $time, want.pixels_even,
                   out_data.pixels_even);
          errs++;
        end
        if (out_data.pixels_odd !== want.pixels_odd) begin
          $display("%0t: pixels_odd expected %h actual %h", $time, want.pixels_odd,
                   out_data.pixels_odd);
          errs++;
        end
      end
    end
  end

  initial begin
    mode_t phase_mode [12];
    phase_mode = '{MODE_TEXT40, MODE_CHUNKY, MODE_TEXT40_COLOR, MODE_TEXT80,
                   MODE_TEXT80_ALT, MODE_HIRES, MODE_HIRES_COLOR, MODE_SUPER,
                   MODE_CHUNKY, MODE_TEXT40, MODE_HIRES_COLOR, MODE_TEXT80};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: glyph store corners, then two renders in every mode
    beats_pending.push_back(write_beat(10'd0, 8'h55));
    beats_pending.push_back(write_beat(10'd1023, 8'hFF));
    beats_pending.push_back(write_beat({7'h41, 3'd3}, 8'hA5));
    beats_pending.push_back(write_beat(10'd512, 8'h00));
    for (int m = 0; m < 8; m++) begin
      set_mode(mode_t'(m));
      beats_pending.push_back(render_beat(3'd7, 8'hFF, 8'h00, 8'h7F, 8'hFF));
      beats_pending.push_back(render_beat(3'd3, 8'hC1, 8'h41, 8'h00, 8'h5A));
    end

    for (int p = 0; p < 12; p++) begin
      set_mode(phase_mode[p]);
      if (p < 4) begin
        snd_idle_pct = 19;
        rcv_idle_pct = 46;
      end else if (p < 8) begin
        snd_idle_pct = 46;
        rcv_idle_pct = 19;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      for (int i = 0; i < 120; i++) beats_pending.push_back(random_beat(25));
      if (p == 1 || p == 9) hold_trigger++;
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (errs == 0) begin
      $display("video_mode_pixel_generator: match");
    end else begin
      $display("video_mode_pixel_generator: mismatch");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("video_mode_pixel_generator: mismatch");
    $finish;
  end

endmodule

[sim.f]
src/vmpg_pkg.sv
src/vmpg_ram.sv
src/vmpg_lane.sv
src/vmpg_merge.sv
src/video_mode_pixel_generator.sv
verif/tb.sv
